// ----- src/point_in_polygon_ray_cast_macros.svh -----
// assertion macros for the point in polygon ray cast block
`ifndef POINT_IN_POLYGON_RAY_CAST_MACROS_SVH
`define POINT_IN_POLYGON_RAY_CAST_MACROS_SVH

`ifndef NO_ASSERTIONS

`define PIPR_ASSERT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pipr assertion failed");

`define PIPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pipr assertion failed");

`else

`define PIPR_ASSERT(label, clk, rst_n, ante, cons)

`define PIPR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- src/pipr_pkg.sv -----
// shared types and constants of the point in polygon ray cast block
package pipr_pkg;

	localparam int COORD_BITS = 32;
	localparam int DIST_BITS  = 32;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] query_x;
		logic signed [COORD_BITS-1:0] query_y;
		logic signed [COORD_BITS-1:0] vertex_x;
		logic signed [COORD_BITS-1:0] vertex_y;
		logic                         last_vertex;
	} pipr_vtx_t;

	typedef struct packed {
		logic                 inside_res;
		logic [DIST_BITS-1:0] distance;
	} pipr_res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCREEN,
		ST_MUL,
		ST_COMB,
		ST_SAT,
		ST_DIV,
		ST_MIN,
		ST_END
	} pipr_state_t;

	typedef struct packed {
		logic load;
		logic init;
		logic mul_setup;
		logic mul_step;
		logic combine;
		logic sat_check;
		logic div_step;
		logic update_min;
		logic end_item;
		logic emit;
	} pipr_cmd_t;

	typedef struct packed {
		logic first;
		logic straddle;
		logic mul_done;
		logic crossing;
		logic sat;
		logic div_done;
		logic last;
		logic res_busy;
	} pipr_sts_t;

endpackage

// ----- src/pipr_ctrl.sv -----
// sequencer for one vertex item: screen, multiply, combine, divide, update
module pipr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                vtx_valid,
	output logic                vtx_ready,
	input  pipr_pkg::pipr_sts_t sts,
	output pipr_pkg::pipr_cmd_t cmd
);

	pipr_pkg::pipr_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pipr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd       = '0;
		vtx_ready = 1'b0;
		state_d   = state_q;
		unique case (state_q)
			pipr_pkg::ST_IDLE: begin
				vtx_ready = 1'b1;
				if (vtx_valid) begin
					cmd.load = 1'b1;
					state_d  = pipr_pkg::ST_SCREEN;
				end
			end
			pipr_pkg::ST_SCREEN: begin
				priority if (sts.first) begin
					cmd.init = 1'b1;
					state_d  = pipr_pkg::ST_END;
				end else if (sts.straddle) begin
					cmd.mul_setup = 1'b1;
					state_d       = pipr_pkg::ST_MUL;
				end else begin
					state_d = pipr_pkg::ST_END;
				end
			end
			pipr_pkg::ST_MUL: begin
				cmd.mul_step = 1'b1;
				if (sts.mul_done) begin
					state_d = pipr_pkg::ST_COMB;
				end
			end
			pipr_pkg::ST_COMB: begin
				cmd.combine = 1'b1;
				state_d     = sts.crossing ? pipr_pkg::ST_SAT : pipr_pkg::ST_END;
			end
			pipr_pkg::ST_SAT: begin
				cmd.sat_check = 1'b1;
				state_d       = sts.sat ? pipr_pkg::ST_MIN : pipr_pkg::ST_DIV;
			end
			pipr_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) begin
					state_d = pipr_pkg::ST_MIN;
				end
			end
			pipr_pkg::ST_MIN: begin
				cmd.update_min = 1'b1;
				state_d        = pipr_pkg::ST_END;
			end
			pipr_pkg::ST_END: begin
				cmd.end_item = 1'b1;
				// a closing vertex waits here until the result register is free
				if (!sts.last) begin
					state_d = pipr_pkg::ST_IDLE;
				end else if (!sts.res_busy) begin
					cmd.emit = 1'b1;
					state_d  = pipr_pkg::ST_IDLE;
				end
			end
		endcase
	end

endmodule

// ----- src/pipr_dp.sv -----
// datapath: polygon state, shift-add multipliers, restoring divider, result register
`include "point_in_polygon_ray_cast_macros.svh"

module pipr_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  pipr_pkg::pipr_vtx_t vtx_data,
	input  pipr_pkg::pipr_cmd_t cmd,
	output pipr_pkg::pipr_sts_t sts,
	input  logic                res_ready,
	output logic                res_valid,
	output pipr_pkg::pipr_res_t res_data
);

	localparam int CW      = pipr_pkg::COORD_BITS;
	localparam int DB      = pipr_pkg::DIST_BITS;
	localparam int MW      = 2 * CW + 1;
	localparam int NW      = 2 * CW + 2;
	localparam int SW      = CW + DB;
	localparam int DW      = (NW > SW + 1) ? NW : SW + 1;
	localparam int CNT_MAX = (DB > CW) ? DB : CW;
	localparam int CNTW    = $clog2(CNT_MAX);

	pipr_pkg::pipr_vtx_t item_q;
	pipr_pkg::pipr_res_t res_data_q;

	logic signed [CW-1:0] hqx_q, hqy_q, prev_x_q, prev_y_q;
	logic                 awaiting_q, odd_q, res_valid_q;
	logic [DB-1:0]        least_q, quo_q;
	logic [CW:0]          mag_l_q, mag_u_q, q_q;
	logic [CW-1:0]        mw_q, mp_q;
	logic                 al_neg_q, au_neg_q, sat_q;
	logic [MW-1:0]        tl_q, tu_q;
	logic [NW-1:0]        rem_q;
	logic [SW-1:0]        dsh_q;
	logic [CNTW-1:0]      cnt_q;

	// screening of the edge from the previous vertex to this one
	logic              up1, up2, both_left;
	logic signed [CW-1:0] xu, yu, xl, yl;
	logic [CW:0]       al, au, p_full, w_full, q_full, mag_l, mag_u;

	assign up1       = prev_y_q >= hqy_q;
	assign up2       = item_q.vertex_y >= hqy_q;
	assign both_left = (prev_x_q < hqx_q) && (item_q.vertex_x < hqx_q);

	always_comb begin
		if (up1) begin
			xu = prev_x_q;
			yu = prev_y_q;
			xl = item_q.vertex_x;
			yl = item_q.vertex_y;
		end else begin
			xu = item_q.vertex_x;
			yu = item_q.vertex_y;
			xl = prev_x_q;
			yl = prev_y_q;
		end
	end

	assign al     = {xl[CW-1], xl} - {hqx_q[CW-1], hqx_q};
	assign au     = {xu[CW-1], xu} - {hqx_q[CW-1], hqx_q};
	assign p_full = {hqy_q[CW-1], hqy_q} - {yl[CW-1], yl};
	assign w_full = {yu[CW-1], yu} - {hqy_q[CW-1], hqy_q};
	assign q_full = {yu[CW-1], yu} - {yl[CW-1], yl};
	assign mag_l  = al[CW] ? (~al + 1'b1) : al;
	assign mag_u  = au[CW] ? (~au + 1'b1) : au;

	// signed combination of the two cross products
	logic [NW-1:0] op_a, op_b, sum;
	logic          sub, crossing;

	assign sub      = al_neg_q | au_neg_q;
	assign op_a     = al_neg_q ? NW'(tu_q) : NW'(tl_q);
	assign op_b     = al_neg_q ? NW'(tl_q) : NW'(tu_q);
	assign sum      = sub ? (op_a - op_b) : (op_a + op_b);
	assign crossing = sub ? (!sum[NW-1] && (sum != '0)) : (sum != '0);

	// divider compares
	logic          sat, ge;
	logic [DW-1:0] diff;
	logic [DB-1:0] dist_val;

	assign sat      = DW'(rem_q) >= DW'({q_q, {DB{1'b0}}});
	assign ge       = DW'(rem_q) >= DW'(dsh_q);
	assign diff     = DW'(rem_q) - DW'(dsh_q);
	assign dist_val = sat_q ? '1 : quo_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= vtx_data;
		end
		if (cmd.mul_setup) begin
			mag_l_q  <= mag_l;
			mag_u_q  <= mag_u;
			al_neg_q <= al[CW];
			au_neg_q <= au[CW];
			mw_q     <= w_full[CW-1:0];
			mp_q     <= p_full[CW-1:0];
			q_q      <= q_full;
			tl_q     <= '0;
			tu_q     <= '0;
			cnt_q    <= CNTW'(CW - 1);
		end
		if (cmd.mul_step) begin
			tl_q  <= {tl_q[MW-2:0], 1'b0} + (mw_q[CW-1] ? MW'(mag_l_q) : '0);
			tu_q  <= {tu_q[MW-2:0], 1'b0} + (mp_q[CW-1] ? MW'(mag_u_q) : '0);
			mw_q  <= {mw_q[CW-2:0], 1'b0};
			mp_q  <= {mp_q[CW-2:0], 1'b0};
			cnt_q <= cnt_q - 1'b1;
		end
		if (cmd.combine) begin
			rem_q <= sum;
		end
		if (cmd.sat_check) begin
			sat_q <= sat;
			dsh_q <= {q_q, {(DB-1){1'b0}}};
			quo_q <= '0;
			cnt_q <= CNTW'(DB - 1);
		end
		if (cmd.div_step) begin
			if (ge) begin
				rem_q <= NW'(diff);
			end
			quo_q <= {quo_q[DB-2:0], ge};
			dsh_q <= dsh_q >> 1;
			cnt_q <= cnt_q - 1'b1;
		end
		if (cmd.emit) begin
			res_data_q.inside_res <= odd_q;
			res_data_q.distance   <= odd_q ? least_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q  <= 1'b1;
			hqx_q       <= '0;
			hqy_q       <= '0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			odd_q       <= 1'b0;
			least_q     <= '1;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.init) begin
				hqx_q      <= item_q.query_x;
				hqy_q      <= item_q.query_y;
				odd_q      <= 1'b0;
				least_q    <= '1;
				awaiting_q <= 1'b0;
			end
			if (cmd.combine && crossing) begin
				odd_q <= ~odd_q;
			end
			if (cmd.update_min && (dist_val < least_q)) begin
				least_q <= dist_val;
			end
			if (cmd.end_item) begin
				prev_x_q <= item_q.vertex_x;
				prev_y_q <= item_q.vertex_y;
			end
			if (cmd.emit) begin
				awaiting_q  <= 1'b1;
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		sts          = '0;
		sts.first    = awaiting_q;
		sts.straddle = (up1 != up2) && !both_left;
		sts.mul_done = cnt_q == '0;
		sts.crossing = crossing;
		sts.sat      = sat;
		sts.div_done = cnt_q == '0;
		sts.last     = item_q.last_vertex;
		sts.res_busy = res_valid_q && !res_ready;
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_data_q;

	`PIPR_ASSERT(a_emit_free, clk, arst_n, cmd.emit, !(res_valid_q && !res_ready))
	`PIPR_ASSERT(a_div_nosat, clk, arst_n, cmd.div_step, !sat_q)
	`PIPR_ASSERT(a_rem_bound, clk, arst_n, cmd.div_step, DW'(rem_q) < DW'({dsh_q, 1'b0}))
	`PIPR_ASSERT(a_out_zero, clk, arst_n, res_valid_q && !res_data_q.inside_res, res_data_q.distance == '0)
	`PIPR_ASSERT_NEXT(a_emit_rearm, clk, arst_n, cmd.emit, awaiting_q && res_valid_q)

endmodule

// ----- src/point_in_polygon_ray_cast.sv -----
// top level of the point in polygon ray cast block
//
// vtx channel: one item per polygon vertex, valid/ready. the query point is taken
// from the first item of a polygon; last_vertex closes the polygon. edges join
// consecutive vertices only, the path is not closed.
// res channel: one item per polygon, sent after its closing vertex: inside_res is
// the parity of crossings strictly right of the query point, distance the floored
// nearest crossing distance (saturated) when inside, else zero.
// one vertex is in work at a time; vtx_ready is high only between vertices.
// per vertex, a first vertex or an edge that cannot cross goes from screening to
// the end step; other edges run the multipliers and combine, and a crossing then
// the saturation check, the divider unless it saturates, and the min update. the
// cross products come from two shift-add multipliers at one bit a cycle and the
// distance from a restoring divider at one quotient bit a cycle.
// the result appears in the cycle after the closing vertex finishes. a result that
// waits on res_ready does not block the next vertices; only the next closing
// vertex holds until the result register is free.
// reset clears the polygon state and drops any result not yet taken.
module point_in_polygon_ray_cast (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                vtx_valid,
	output logic                vtx_ready,
	input  pipr_pkg::pipr_vtx_t vtx_data,
	output logic                res_valid,
	input  logic                res_ready,
	output pipr_pkg::pipr_res_t res_data
);

	pipr_pkg::pipr_cmd_t cmd;
	pipr_pkg::pipr_sts_t sts;

	pipr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.vtx_valid (vtx_valid),
		.vtx_ready (vtx_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	pipr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.vtx_data  (vtx_data),
		.cmd       (cmd),
		.sts       (sts),
		.res_ready (res_ready),
		.res_valid (res_valid),
		.res_data  (res_data)
	);

endmodule
